[rtl/volume_offset_table_parser_defines.svh]
// Assertion macros shared by the offset table parser modules.
`ifndef VOLUME_OFFSET_TABLE_PARSER_DEFINES_SVH
`define VOLUME_OFFSET_TABLE_PARSER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define VOT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define VOT_ASSERT_IMPL(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`endif

[rtl/vot_pkg.sv]
// Types and constants of the volume offset table parser.
package vot_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_MEMBER = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   // Member types taken from the head magic.
   localparam logic [1:0] TYPE_BINARY   = 2'd0;
   localparam logic [1:0] TYPE_GRAPHICS = 2'd1;
   localparam logic [1:0] TYPE_VOICE    = 2'd2;

   localparam logic [31:0] MAGIC_VOICE    = 32'h6165_7243;
   localparam logic [31:0] MAGIC_GRAPHICS = 32'h1d48_5047;
   localparam logic [31:0] MIN_TABLE_BYTES = 32'd8;
   localparam logic [31:0] MIN_FILE_BYTES  = 32'd16;

   // Register index of file_size in the configuration space.
   localparam logic REG_FILE_SIZE = 1'b0;

   // Result queue depth.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef enum logic [1:0] {
      PHASE_SIZE,
      PHASE_TABLE
   } phase_type;

   typedef struct packed {
      logic [31:0] table_word;
      logic [31:0] head_word;
      logic [2:0]  head_bytes;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [14:0] member_number;
      logic [13:0] table_index;
      logic [31:0] member_offset;
      logic [31:0] member_size;
      logic [1:0]  member_type;
      logic        last_result;
   } rsp_type;

   // Up to two results produced by one table word, first in order first.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

[rtl/vot_csr.sv]
// APB-style register file holding the volume size.
module vot_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [31:0] file_size
);
   import vot_pkg::*;

   logic [31:0] file_size_ff;
   logic [31:0] file_size_in;
   logic        wr_hit;

   // A write lands in the access phase of a transfer to the size register.
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_FILE_SIZE);

   always_comb begin
      file_size_in = file_size_ff;
      if (wr_hit) begin
         file_size_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         file_size_ff <= '0;
      end else begin
         file_size_ff <= file_size_in;
      end
   end

   // Reads of unmapped addresses return zero.
   assign prdata    = (paddr[2] == REG_FILE_SIZE) ? file_size_ff : 32'd0;
   assign pready    = 1'b1;
   assign file_size = file_size_ff;

endmodule

[rtl/vot_walk.sv]
// Input word register, table state and the per-word checks.
`include "volume_offset_table_parser_defines.svh"

module vot_walk #(
   parameter int MAX_TABLE_BYTES = 65536
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  vot_pkg::req_type req_data,
   input  logic [31:0]      file_size,
   input  logic             room,
   output vot_pkg::push_type push
);
   import vot_pkg::*;

   localparam int WORDS_MAX = MAX_TABLE_BYTES / 4;
   localparam int CNT_W     = $clog2(WORDS_MAX + 1);
   localparam int TB_W      = $clog2(MAX_TABLE_BYTES + 1);

   // Input word register.
   logic    in_valid_ff, in_valid_in;
   req_type in_ff, in_in;
   logic    take;

   // Table state.
   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   words_expected_ff, words_expected_in;
   logic [CNT_W-1:0]   word_index_ff, word_index_in;
   logic [TB_W-1:0]    table_bytes_ff, table_bytes_in;
   logic [31:0]        prev_entry_ff, prev_entry_in;
   logic [31:0]        prev_head_ff, prev_head_in;
   logic [2:0]         prev_bytes_ff, prev_bytes_in;
   logic [CNT_W-1:0]   member_count_ff, member_count_in;
   logic               sentinel_ff, sentinel_in;
   logic               failed_ff, failed_in;
   logic               stopped_ff, stopped_in;

   // Per-word working values.
   logic [31:0]      w, f, prev, size, room_left, idx_wide, cnt_wide;
   logic             size_bad, member_bad, emit_member, emit_verdict, accept;
   logic [CNT_W-1:0] idx_next;
   rsp_type          r_member, r_verdict;

   function automatic logic [1:0] head_type(input logic [31:0] word,
                                            input logic [2:0] avail,
                                            input logic [31:0] msize);
      logic [1:0] t;
      t = TYPE_BINARY;
      if (avail >= 3'd4 && msize >= 32'd4) begin
         if (word == MAGIC_GRAPHICS) begin
            t = TYPE_GRAPHICS;
         end else if (word == MAGIC_VOICE) begin
            t = TYPE_VOICE;
         end
      end
      return t;
   endfunction

   // A held word is worked off when the queue has room for two results.
   assign take      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || take;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_in       = req_data;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   // Shared values for both phases.
   assign w         = in_ff.table_word;
   assign f         = file_size;
   assign prev      = prev_entry_ff;
   assign size      = w - prev;
   assign room_left = f - prev;
   assign idx_next  = word_index_ff + 1'b1;
   assign idx_wide  = 32'(word_index_ff) - 32'd1;

   // Size word checks.
   assign size_bad = (f < MIN_FILE_BYTES) || (w < MIN_TABLE_BYTES) ||
                     (w > 32'(MAX_TABLE_BYTES)) || (w[1:0] != 2'b00) || (w > f);

   // A member whose bounds fall outside the data area fails the table.
   assign member_bad = (w < prev) || (prev < 32'(table_bytes_ff)) || (f < prev) ||
                       (size > room_left);

   // Next state and results.
   always_comb begin
      phase_in          = phase_ff;
      words_expected_in = words_expected_ff;
      word_index_in     = word_index_ff;
      table_bytes_in    = table_bytes_ff;
      prev_entry_in     = prev_entry_ff;
      prev_head_in      = prev_head_ff;
      prev_bytes_in     = prev_bytes_ff;
      member_count_in   = member_count_ff;
      sentinel_in       = sentinel_ff;
      failed_in         = failed_ff;
      stopped_in        = stopped_ff;
      emit_member       = 1'b0;
      emit_verdict      = 1'b0;
      accept            = 1'b0;

      if (take) begin
         case (phase_ff)
            PHASE_SIZE: begin
               if (size_bad) begin
                  emit_verdict = 1'b1;
               end else begin
                  phase_in          = PHASE_TABLE;
                  table_bytes_in    = w[TB_W-1:0];
                  words_expected_in = w[CNT_W+1:2];
                  word_index_in     = CNT_W'(1);
                  prev_entry_in     = w;
                  prev_head_in      = in_ff.head_word;
                  prev_bytes_in     = in_ff.head_bytes;
               end
            end
            PHASE_TABLE: begin
               // Ordering and sentinel checks.
               if (!sentinel_ff) begin
                  if (prev == f && w == 32'd0) begin
                     sentinel_in = 1'b1;
                  end else if (prev[31] || prev > f || w < prev) begin
                     failed_in = 1'b1;
                  end
               end else if (w != 32'd0) begin
                  failed_in = 1'b1;
               end

               // Member walk; a repeated offset is an empty member.
               if (!stopped_ff) begin
                  if (w == 32'd0) begin
                     stopped_in = 1'b1;
                  end else if (w != prev) begin
                     if (member_bad) begin
                        failed_in = 1'b1;
                     end else if (!failed_in) begin
                        member_count_in = member_count_ff + 1'b1;
                        emit_member     = 1'b1;
                     end
                  end
               end

               prev_entry_in = w;
               prev_head_in  = in_ff.head_word;
               prev_bytes_in = in_ff.head_bytes;
               word_index_in = idx_next;

               // The last word closes the table with a verdict.
               if (idx_next >= words_expected_ff) begin
                  if (!sentinel_in && w != f) begin
                     failed_in = 1'b1;
                  end
                  accept       = !failed_in && (member_count_in != '0);
                  emit_verdict = 1'b1;
               end
            end
            default: begin
               emit_verdict = 1'b1;
            end
         endcase

         // Any verdict starts over with a fresh table.
         if (emit_verdict) begin
            phase_in          = PHASE_SIZE;
            words_expected_in = '0;
            word_index_in     = '0;
            table_bytes_in    = '0;
            prev_entry_in     = '0;
            prev_head_in      = '0;
            prev_bytes_in     = '0;
            member_count_in   = '0;
            sentinel_in       = 1'b0;
            failed_in         = 1'b0;
            stopped_in        = 1'b0;
         end
      end
   end

   // Result words.
   assign cnt_wide = (phase_ff == PHASE_TABLE) ?
                     32'(member_count_ff) + (emit_member ? 32'd1 : 32'd0) : 32'd0;

   always_comb begin
      r_member.kind          = KIND_MEMBER;
      r_member.member_number = cnt_wide[14:0];
      r_member.table_index   = idx_wide[13:0];
      r_member.member_offset = prev;
      r_member.member_size   = size;
      r_member.member_type   = head_type(prev_head_ff, prev_bytes_ff, size);
      r_member.last_result   = !emit_verdict;

      r_verdict.kind          = accept ? KIND_ACCEPT : KIND_REJECT;
      r_verdict.member_number = cnt_wide[14:0];
      r_verdict.table_index   = '0;
      r_verdict.member_offset = '0;
      r_verdict.member_size   = '0;
      r_verdict.member_type   = TYPE_BINARY;
      r_verdict.last_result   = 1'b1;

      push.first  = emit_member ? r_member : r_verdict;
      push.second = r_verdict;
      push.count  = {1'b0, emit_member} + {1'b0, emit_verdict};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         phase_ff          <= PHASE_SIZE;
         words_expected_ff <= '0;
         word_index_ff     <= '0;
         table_bytes_ff    <= '0;
         prev_entry_ff     <= '0;
         prev_head_ff      <= '0;
         prev_bytes_ff     <= '0;
         member_count_ff   <= '0;
         sentinel_ff       <= 1'b0;
         failed_ff         <= 1'b0;
         stopped_ff        <= 1'b0;
      end else begin
         in_valid_ff       <= in_valid_in;
         phase_ff          <= phase_in;
         words_expected_ff <= words_expected_in;
         word_index_ff     <= word_index_in;
         table_bytes_ff    <= table_bytes_in;
         prev_entry_ff     <= prev_entry_in;
         prev_head_ff      <= prev_head_in;
         prev_bytes_ff     <= prev_bytes_in;
         member_count_ff   <= member_count_in;
         sentinel_ff       <= sentinel_in;
         failed_ff         <= failed_in;
         stopped_ff        <= stopped_in;
      end
   end

   // The payload register needs no reset.
   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   `VOT_ASSERT_IMPL(a_push_needs_room, push.count != 2'd0, room,
                    "result pushed while queue had no room")
   `VOT_ASSERT_IMPL(a_pair_order, push.count == 2'd2,
                    push.first.kind == KIND_MEMBER && push.second.last_result &&
                    !push.first.last_result, "two results not member then verdict")
   `VOT_ASSERT_IMPL(a_table_index_bounded, phase_ff == PHASE_TABLE,
                    word_index_ff != '0 && word_index_ff < words_expected_ff,
                    "word index outside table")

endmodule

[rtl/vot_rsp_fifo.sv]
// Small result queue taking up to two words per cycle and giving one.
`include "volume_offset_table_parser_defines.svh"

module vot_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  vot_pkg::push_type push,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vot_pkg::rsp_type  rsp_data
);
   import vot_pkg::*;

   rsp_type              mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem[rd_ptr_ff];

   // Room for a worst-case pair, regardless of a pop this cycle.
   assign room = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + (pop ? RSP_PTR_W'(1) : RSP_PTR_W'(0));
      count_in  = count_ff + RSP_CNT_W'(push.count) - (pop ? RSP_CNT_W'(1) : RSP_CNT_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage writes; the second word goes to the following slot.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_ff + RSP_PTR_W'(1)] <= push.second;
      end
   end

   `VOT_ASSERT(a_count_bounded, count_ff <= RSP_CNT_W'(RSP_DEPTH),
               "result queue count above depth")
   `VOT_ASSERT_IMPL(a_no_overflow, push.count != 2'd0,
                    32'(count_ff) + 32'(push.count) <= 32'(RSP_DEPTH) + (pop ? 32'd1 : 32'd0),
                    "result queue overflow")

endmodule

[rtl/volume_offset_table_parser.sv]
// Top level of the volume offset table parser.
//
// Table words enter on the req_ channel (valid/ready); each word carries the
// table entry and the first head bytes at that offset. The first word of a
// table is its byte size; the following words are the entries.
// Results leave on the rsp_ channel: a member word for each non-empty member
// and one accept or reject word after the last entry (or at once for a bad
// size word). last_result marks the final word caused by one input word.
// Member words mean something only if the verdict that follows is accept.
// file_size is set through the APB-style port at byte address 0.
// Latency: a result word passes the input word register and then the result
// queue. Throughput: one input word per cycle while the queue has room; a word
// with both a member and a verdict puts two words on the output channel, the bound then.
// Words are held in a four-entry result queue; when the receiver stalls the
// queue fills and req_ready drops once fewer than two entries are free.
// Reset (synchronous) clears file_size, empties the queue and waits for a
// size word.
module volume_offset_table_parser #(
   parameter int MAX_TABLE_BYTES = 65536
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  vot_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output vot_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import vot_pkg::*;

   logic [31:0] file_size;
   logic        room;
   push_type    push;

   // Configuration register.
   vot_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .file_size (file_size)
   );

   // Table checks and member extraction.
   vot_walk #(
      .MAX_TABLE_BYTES (MAX_TABLE_BYTES)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .file_size (file_size),
      .room      (room),
      .push      (push)
   );

   // Result queue.
   vot_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
